FILE: design/dotted_dda_line_rasterizer_core_macros.svh
// Assertion macros used by the checker of the dotted DDA line rasterizer.
`ifndef DOTTED_DDA_LINE_RASTERIZER_CORE_MACROS_SVH
`define DOTTED_DDA_LINE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define DDA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define DDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/dda_pkg.sv
// Shared types and constants of the dotted DDA line rasterizer.
package dda_pkg;

   // Coordinate width and fixed-point format.
   localparam int COORD_BITS = 8;
   localparam int FRAC_BITS  = 16;
   localparam int DOT_PERIOD = 5;

   // Derived widths.
   localparam int DIFF_W    = COORD_BITS + 1;
   localparam int DVD_W     = COORD_BITS + FRAC_BITS;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int INC_W     = FRAC_BITS + 2;
   localparam int POS_W     = COORD_BITS + FRAC_BITS + 1;
   localparam int DIV_CNT_W = $clog2(DVD_W);
   localparam int PHASE_W   = $clog2(DOT_PERIOD);

   // Stream word widths, padded to whole bytes.
   localparam int REQ_W = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((2 * COORD_BITS + 7) / 8) * 8;

   // Line queue depth.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Front-end sequencer states.
   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_PUSH
   } front_state_type;

   // One classified line, ready to be walked.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [INC_W-1:0]      inc_x;
      logic signed [INC_W-1:0]      inc_y;
      logic [COORD_BITS-1:0]        steps;
   } line_type;

   // Queue handshake between front and back.
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

FILE: design/dda_front.sv
// Front end: accepts a line, finds the step count and divides out the increments.
module dda_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dda_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        fifo_full,
   output logic                        fifo_push,
   output dda_pkg::line_type           line_out
);

   localparam int CB = dda_pkg::COORD_BITS;

   dda_pkg::front_state_type state_ff, state_in;

   logic signed [CB-1:0]            sx_ff, sx_in, sy_ff, sy_in;
   logic [CB-1:0]                   steps_ff, steps_in;
   logic                            negx_ff, negx_in, negy_ff, negy_in;
   logic [dda_pkg::DVD_W-1:0]       dvdx_ff, dvdx_in, dvdy_ff, dvdy_in;
   logic [CB-1:0]                   remx_ff, remx_in, remy_ff, remy_in;
   logic [dda_pkg::QUO_W-1:0]       qx_ff, qx_in, qy_ff, qy_in;
   logic [dda_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   // Field unpacking and step count of the incoming word.
   logic signed [CB-1:0]                req_sx, req_sy, req_ex, req_ey;
   logic signed [dda_pkg::DIFF_W-1:0]   dx, dy;
   logic [CB-1:0]                       magx, magy, steps_w;
   logic [CB:0]                         trialx, trialy, diffx, diffy;
   logic                                gex, gey;
   logic [dda_pkg::INC_W-1:0]           qx_ext, qy_ext;

   assign req_sx = req_tdata[CB-1:0];
   assign req_sy = req_tdata[2*CB-1:CB];
   assign req_ex = req_tdata[3*CB-1:2*CB];
   assign req_ey = req_tdata[4*CB-1:3*CB];

   assign dx = dda_pkg::DIFF_W'(req_ex) - dda_pkg::DIFF_W'(req_sx);
   assign dy = dda_pkg::DIFF_W'(req_ey) - dda_pkg::DIFF_W'(req_sy);
   assign magx = dx[CB] ? CB'(-dx) : CB'(dx);
   assign magy = dy[CB] ? CB'(-dy) : CB'(dy);
   assign steps_w = (magx > magy) ? magx : magy;

   // One restoring division bit per cycle for each axis.
   assign trialx = {remx_ff, dvdx_ff[dda_pkg::DVD_W-1]};
   assign trialy = {remy_ff, dvdy_ff[dda_pkg::DVD_W-1]};
   assign diffx  = trialx - {1'b0, steps_ff};
   assign diffy  = trialy - {1'b0, steps_ff};
   assign gex    = trialx >= {1'b0, steps_ff};
   assign gey    = trialy >= {1'b0, steps_ff};

   // Signed increments from the quotient magnitudes.
   assign qx_ext = {1'b0, qx_ff};
   assign qy_ext = {1'b0, qy_ff};
   assign line_out.start_x = sx_ff;
   assign line_out.start_y = sy_ff;
   assign line_out.inc_x   = negx_ff ? -qx_ext : qx_ext;
   assign line_out.inc_y   = negy_ff ? -qy_ext : qy_ext;
   assign line_out.steps   = steps_ff;

   // Sequencer: take a line, divide, hand it to the queue.
   always_comb begin
      state_in   = state_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      steps_in   = steps_ff;
      negx_in    = negx_ff;
      negy_in    = negy_ff;
      dvdx_in    = dvdx_ff;
      dvdy_in    = dvdy_ff;
      remx_in    = remx_ff;
      remy_in    = remy_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      fifo_push  = 1'b0;
      unique case (state_ff)
         dda_pkg::FRONT_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sx_in    = req_sx;
               sy_in    = req_sy;
               steps_in = steps_w;
               negx_in  = dx[CB];
               negy_in  = dy[CB];
               dvdx_in  = {magx, {dda_pkg::FRAC_BITS{1'b0}}};
               dvdy_in  = {magy, {dda_pkg::FRAC_BITS{1'b0}}};
               remx_in  = '0;
               remy_in  = '0;
               qx_in    = '0;
               qy_in    = '0;
               cnt_in   = dda_pkg::DIV_CNT_W'(dda_pkg::DVD_W - 1);
               // Lines shorter than one dot period produce nothing.
               if (steps_w >= CB'(dda_pkg::DOT_PERIOD)) begin
                  state_in = dda_pkg::FRONT_DIV;
               end
            end
         end
         dda_pkg::FRONT_DIV: begin
            dvdx_in = {dvdx_ff[dda_pkg::DVD_W-2:0], 1'b0};
            dvdy_in = {dvdy_ff[dda_pkg::DVD_W-2:0], 1'b0};
            remx_in = gex ? diffx[CB-1:0] : trialx[CB-1:0];
            remy_in = gey ? diffy[CB-1:0] : trialy[CB-1:0];
            qx_in   = {qx_ff[dda_pkg::QUO_W-2:0], gex};
            qy_in   = {qy_ff[dda_pkg::QUO_W-2:0], gey};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = dda_pkg::FRONT_PUSH;
            end
         end
         dda_pkg::FRONT_PUSH: begin
            if (!fifo_full) begin
               fifo_push = 1'b1;
               state_in  = dda_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = dda_pkg::FRONT_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dda_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers of the divider.
   always_ff @(posedge clock) begin
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      steps_ff <= steps_in;
      negx_ff  <= negx_in;
      negy_ff  <= negy_in;
      dvdx_ff  <= dvdx_in;
      dvdy_ff  <= dvdy_in;
      remx_ff  <= remx_in;
      remy_ff  <= remy_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      cnt_ff   <= cnt_in;
   end

endmodule

FILE: design/dda_fifo.sv
// Short queue of classified lines between the front and back ends.
module dda_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  dda_pkg::fifo_ctrl_type ctrl,
   output dda_pkg::fifo_stat_type stat,
   input  dda_pkg::line_type      wr_line,
   output dda_pkg::line_type      rd_line
);

   dda_pkg::line_type                entry_ff [dda_pkg::FIFO_DEPTH];
   logic [dda_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dda_pkg::FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                             do_push, do_pop;

   assign stat.full  = count_ff == dda_pkg::FIFO_CNT_W'(dda_pkg::FIFO_DEPTH);
   assign stat.empty = count_ff == '0;
   assign do_push    = ctrl.push && !stat.full;
   assign do_pop     = ctrl.pop && !stat.empty;
   assign rd_line    = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_line;
      end
   end

endmodule

FILE: design/dda_back.sv
// Back end: one step per cycle unless stalled; emits every fifth dot.
module dda_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fifo_empty,
   output logic                              fifo_pop,
   input  dda_pkg::line_type                 line_in,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dda_pkg::COORD_BITS-1:0]    dot_x,
   output logic [dda_pkg::COORD_BITS-1:0]    dot_y,
   output logic                              rsp_tlast
);

   localparam int CB = dda_pkg::COORD_BITS;
   localparam int PW = dda_pkg::POS_W;
   localparam int FB = dda_pkg::FRAC_BITS;

   logic                          busy_ff, busy_in;
   logic signed [PW-1:0]          posx_ff, posx_in, posy_ff, posy_in;
   logic signed [PW-1:0]          incx_ff, incx_in, incy_ff, incy_in;
   logic [CB-1:0]                 rem_ff, rem_in;
   logic [dda_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic                          out_valid_ff, out_valid_in;
   logic [CB-1:0]                 out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                          out_last_ff, out_last_in;

   logic                          emit, advance;
   logic signed [PW-1:0]          halfx, halfy, roundx, roundy;

   // Round half up, then truncate toward zero.
   assign halfx  = posx_ff + PW'(1 << (FB - 1));
   assign halfy  = posy_ff + PW'(1 << (FB - 1));
   assign roundx = halfx[PW-1] ? (halfx + PW'((1 << FB) - 1)) >>> FB : halfx >>> FB;
   assign roundy = halfy[PW-1] ? (halfy + PW'((1 << FB) - 1)) >>> FB : halfy >>> FB;

   // A dot step waits while the previous dot is still held.
   assign emit    = busy_ff && (phase_ff == dda_pkg::PHASE_W'(dda_pkg::DOT_PERIOD - 1));
   assign advance = busy_ff && !(emit && out_valid_ff && !rsp_tready);
   assign fifo_pop = !busy_ff && !fifo_empty;

   assign rsp_tvalid = out_valid_ff;
   assign dot_x      = out_x_ff;
   assign dot_y      = out_y_ff;
   assign rsp_tlast  = out_last_ff;

   // Step walker and output word register.
   always_comb begin
      busy_in      = busy_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      incx_in      = incx_ff;
      incy_in      = incy_ff;
      rem_in       = rem_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      if (fifo_pop) begin
         busy_in  = 1'b1;
         posx_in  = PW'(line_in.start_x) <<< FB;
         posy_in  = PW'(line_in.start_y) <<< FB;
         incx_in  = PW'(line_in.inc_x);
         incy_in  = PW'(line_in.inc_y);
         rem_in   = line_in.steps - 1'b1;
         phase_in = '0;
      end else if (advance) begin
         if (emit) begin
            out_valid_in = 1'b1;
            out_x_in     = roundx[CB-1:0];
            out_y_in     = roundy[CB-1:0];
            out_last_in  = rem_ff < CB'(dda_pkg::DOT_PERIOD);
            phase_in     = '0;
         end else begin
            phase_in = phase_ff + 1'b1;
         end
         posx_in = posx_ff + incx_ff;
         posy_in = posy_ff + incy_ff;
         rem_in  = rem_ff - 1'b1;
         if (rem_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      posx_ff     <= posx_in;
      posy_ff     <= posy_in;
      incx_ff     <= incx_in;
      incy_ff     <= incy_in;
      rem_ff      <= rem_in;
      phase_ff    <= phase_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: design/dotted_dda_line_rasterizer_core.sv
// Top level of the dotted DDA line rasterizer.
//
// The req channel takes one word per line: start_x, start_y, end_x, end_y,
// each a two's complement coordinate. The rsp channel returns one word per
// emitted dot: pixel_x and pixel_y in tdata, and tlast high on the last dot
// of the line. A line of n steps (the larger of the x and y distances) gives
// floor(n / 5) dots; lines shorter than five steps give no word at all.
// The front end divides both increments with a restoring divider;
// req_tready is low during the division and until the line enters a
// two-entry queue. The back end walks one step per cycle while no due
// dot waits on a held one. The front end divides the next line while
// the back end walks the current one. A stall on rsp holds the current
// dot; the walker keeps stepping until the next dot is due and then
// waits. Reset clears the queue, the walker and the output register; no
// word is pending after reset.
module dotted_dda_line_rasterizer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: start_x, start_y, end_x, end_y.
   input  logic [dda_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: pixel_x, pixel_y.
   output logic [dda_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);

   dda_pkg::fifo_ctrl_type                fifo_ctrl;
   dda_pkg::fifo_stat_type                fifo_stat;
   dda_pkg::line_type                     front_line, back_line;
   logic [dda_pkg::COORD_BITS-1:0]        dot_x, dot_y;
   logic                                  fifo_push, fifo_pop;

   dda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fifo_full  (fifo_stat.full),
      .fifo_push  (fifo_push),
      .line_out   (front_line)
   );

   // Queue controls from both ends.
   assign fifo_ctrl = '{push: fifo_push, pop: fifo_pop};

   dda_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (fifo_ctrl),
      .stat    (fifo_stat),
      .wr_line (front_line),
      .rd_line (back_line)
   );

   dda_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_stat.empty),
      .fifo_pop   (fifo_pop),
      .line_in    (back_line),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dot_x      (dot_x),
      .dot_y      (dot_y),
      .rsp_tlast  (rsp_tlast)
   );

   // Pack the dot word, zero padded to whole bytes.
   assign rsp_tdata = dda_pkg::RSP_W'({dot_y, dot_x});

endmodule

FILE: design/dda_checker.sv
// Port-level checker of the dotted DDA line rasterizer and its bind.
`include "dotted_dda_line_rasterizer_core_macros.svh"

module dda_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [dda_pkg::REQ_W-1:0]     req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [dda_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                          rsp_tlast
);

   // Reset leaves no dot pending.
   `DDA_ASSERT_NEXT(a_reset_no_dot, clock, 1'b0, reset, !rsp_tvalid, "dot pending after reset")

   // Reset returns the front end to taking lines.
   `DDA_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_tready, "req not ready after reset")

   // A waiting line word stays offered and unchanged until it is taken.
   `DDA_ASSERT_NEXT(a_req_hold, clock, reset, req_tvalid && !req_tready, req_tvalid && $stable(req_tdata), "waiting line word changed")

   // A stalled dot word holds its value and its last mark.
   `DDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled dot changed")

endmodule

bind dotted_dda_line_rasterizer_core dda_checker u_dda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: dv/dotted_dda_line_rasterizer_core_tb.sv
// Self-checking testbench for the dotted DDA line rasterizer core.
`timescale 1ns / 100ps

module dotted_dda_line_rasterizer_core_tb;

   localparam int USE_MODEL     = -1;
   localparam int RANDOM_LINES  = 336;
   localparam int DIRECTED_ROWS = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 300;

   typedef logic signed [dda_pkg::COORD_BITS-1:0] coord_type;

   // One expected dot word.
   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } dot_word_type;

   // One line of stimulus. typed_n is the dot count read off by hand, or
   // USE_MODEL when the dots come from the predictor. A typed row has at
   // most one dot, and that dot is the last one.
   typedef struct {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      int        typed_n;
      coord_type tx;
      coord_type ty;
   } line_case_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [dda_pkg::REQ_W-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [dda_pkg::RSP_W-1:0] rsp_tdata;
   logic                      rsp_tlast;

   dot_word_type expected_dots[$];
   int           mismatches   = 0;
   int           dots_seen    = 0;
   int           dots_acked   = 0;
   int           rx_stall     = 0;
   int           idle_cycles  = 0;

   dotted_dda_line_rasterizer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, 12 ns period.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Per-step increment: (d * 2^FRAC_BITS) / steps, truncated toward zero.
   function automatic longint step_inc(input longint d, input longint steps);
      longint q;
      q = ((d < 0 ? -d : d) * (longint'(1) << dda_pkg::FRAC_BITS)) / steps;
      return (d < 0) ? -q : q;
   endfunction

   // Truncation toward zero of position plus one half.
   function automatic coord_type round_coord(input longint pos);
      longint p;
      p = pos + (longint'(1) << (dda_pkg::FRAC_BITS - 1));
      if (p >= 0) return coord_type'(p >>> dda_pkg::FRAC_BITS);
      return coord_type'(-((-p) >>> dda_pkg::FRAC_BITS));
   endfunction

   // Walk the line the way the block does and queue every fifth-step dot.
   function automatic void trace_dots(input coord_type sx, input coord_type sy,
                                      input coord_type ex, input coord_type ey);
      longint       dx, dy, steps, inc_x, inc_y, pos_x, pos_y, last_step;
      dot_word_type dot;
      dx    = longint'(ex) - longint'(sx);
      dy    = longint'(ey) - longint'(sy);
      steps = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) ? (dx < 0 ? -dx : dx)
                                                          : (dy < 0 ? -dy : dy);
      if (steps < dda_pkg::DOT_PERIOD) return;
      inc_x     = step_inc(dx, steps);
      inc_y     = step_inc(dy, steps);
      pos_x     = longint'(sx) * (longint'(1) << dda_pkg::FRAC_BITS);
      pos_y     = longint'(sy) * (longint'(1) << dda_pkg::FRAC_BITS);
      last_step = steps - (steps % dda_pkg::DOT_PERIOD);
      for (longint i = 1; i <= steps; i++) begin
         if (i % dda_pkg::DOT_PERIOD == 0) begin
            dot.x    = round_coord(pos_x);
            dot.y    = round_coord(pos_y);
            dot.last = (i == last_step);
            expected_dots.push_back(dot);
         end
         pos_x += inc_x;
         pos_y += inc_y;
      end
   endfunction

   // A coordinate at one of the two extremes, or anywhere.
   function automatic int corner_coord();
      case ($urandom_range(0, 2))
         0: return -128;
         1: return 127;
         default: return int'($urandom_range(0, 255)) - 128;
      endcase
   endfunction

   // Random line: mostly anywhere, some short, some on an axis or a
   // diagonal, some pinned to the corners.
   function automatic line_case_type random_line();
      int            sx, sy, ex, ey, dx, dy, kind;
      line_case_type row;
      sx   = int'($urandom_range(0, 255)) - 128;
      sy   = int'($urandom_range(0, 255)) - 128;
      ex   = int'($urandom_range(0, 255)) - 128;
      ey   = int'($urandom_range(0, 255)) - 128;
      kind = $urandom_range(0, 9);
      if (kind == 6 || kind == 7) begin
         dx = int'($urandom_range(0, 18)) - 9;
         dy = int'($urandom_range(0, 18)) - 9;
         ex = sx + dx;
         ey = sy + dy;
         if (ex > 127 || ex < -128) ex = sx - dx;
         if (ey > 127 || ey < -128) ey = sy - dy;
      end else if (kind == 8) begin
         case ($urandom_range(0, 2))
            0: ey = sy;
            1: ex = sx;
            default: begin
               ey = sy + (ex - sx);
               if (ey > 127 || ey < -128) ey = sy - (ex - sx);
               if (ey > 127 || ey < -128) ey = sy;
            end
         endcase
      end else if (kind == 9) begin
         sx = corner_coord();
         sy = corner_coord();
         ex = corner_coord();
         ey = corner_coord();
      end
      row.sx      = coord_type'(sx);
      row.sy      = coord_type'(sy);
      row.ex      = coord_type'(ex);
      row.ey      = coord_type'(ey);
      row.typed_n = USE_MODEL;
      row.tx      = '0;
      row.ty      = '0;
      return row;
   endfunction

   // Offer one line word after an idle gap and hold it until it is taken.
   task automatic drive_line(input line_case_type row, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row.ey, row.ex, row.sy, row.sx};
      do @(posedge clock); while (!req_tready);
   endtask

   // Lower valid and hold off until every queued dot has come back.
   task automatic drain_dots();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_dots.size() != 0) @(posedge clock);
   endtask

   // Result word checker.
   always @(posedge clock) begin
      dot_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         dots_seen++;
         if (expected_dots.size() == 0) begin
            $display("%0t: unexpected dot word x=%0d y=%0d last=%0b", $time,
                     $signed(rsp_tdata[7:0]), $signed(rsp_tdata[15:8]), rsp_tlast);
            mismatches++;
         end else begin
            want = expected_dots.pop_front();
            if (rsp_tdata[7:0] !== want.x) begin
               $display("%0t: pixel_x expected %0d, got %0d", $time, want.x,
                        $signed(rsp_tdata[7:0]));
               mismatches++;
            end
            if (rsp_tdata[15:8] !== want.y) begin
               $display("%0t: pixel_y expected %0d, got %0d", $time, want.y,
                        $signed(rsp_tdata[15:8]));
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_dot expected %0b, got %0b", $time, want.last,
                        rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // Receiver: a fresh random stall after each taken word, with
   // calm stretches that take every word at once.
   always @(negedge clock) begin
      if (dots_seen != dots_acked) begin
         dots_acked = dots_seen;
         rx_stall   = ((dots_seen / 64) % 4 == 3) ? 0 : $urandom_range(0, 6);
      end
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("dotted_dda_line_rasterizer_core_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed table, then random lines.
   initial begin
      line_case_type directed_lines[DIRECTED_ROWS];
      line_case_type row;
      dot_word_type  dot;
      int            gap;

      directed_lines = '{
         // Zero length, including both extremes and all ones.
         '{0, 0, 0, 0, 0, 0, 0},
         '{-128, -128, -128, -128, 0, 0, 0},
         '{127, 127, 127, 127, 0, 0, 0},
         '{-1, -1, -1, -1, 0, 0, 0},
         // Short lines of four steps.
         '{0, 0, 4, 0, 0, 0, 0},
         '{10, -10, 6, -13, 0, 0, 0},
         '{-128, 127, -124, 124, 0, 0, 0},
         // Five to ten steps: one dot per five steps, taken before each fifth advance.
         '{0, 0, 5, 0, 1, 4, 0},
         '{0, 0, 0, 5, 1, 0, 4},
         '{0, 0, -5, 0, USE_MODEL, 0, 0},
         '{0, 0, 0, -5, USE_MODEL, 0, 0},
         '{0, 0, 5, 5, USE_MODEL, 0, 0},
         '{0, 0, -5, -5, USE_MODEL, 0, 0},
         '{3, 7, -2, 9, USE_MODEL, 0, 0},
         '{0, 0, 9, 0, USE_MODEL, 0, 0},
         '{0, 0, 10, 3, USE_MODEL, 0, 0},
         // Full-range diagonals and axes, then two other long lines.
         '{-128, -128, 127, 127, USE_MODEL, 0, 0},
         '{127, 127, -128, -128, USE_MODEL, 0, 0},
         '{-128, 127, 127, -128, USE_MODEL, 0, 0},
         '{127, -128, -128, 127, USE_MODEL, 0, 0},
         '{-128, 0, 127, 0, USE_MODEL, 0, 0},
         '{0, -128, 0, 127, USE_MODEL, 0, 0},
         '{-128, -128, 127, -127, USE_MODEL, 0, 0},
         '{1, 2, -126, -100, USE_MODEL, 0, 0}
      };

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lines.
      foreach (directed_lines[i]) begin
         row = directed_lines[i];
         gap = $urandom_range(0, 6);
         drive_line(row, gap);
         if (row.typed_n == USE_MODEL) begin
            trace_dots(row.sx, row.sy, row.ex, row.ey);
         end else if (row.typed_n == 1) begin
            dot.x    = row.tx;
            dot.y    = row.ty;
            dot.last = 1'b1;
            expected_dots.push_back(dot);
         end
      end

      // Let the block run dry before random traffic.
      drain_dots();
      repeat (40) @(posedge clock);

      // Random lines with calm stretches every so often.
      for (int n = 0; n < RANDOM_LINES; n++) begin
         if (n == RANDOM_LINES / 2) begin
            drain_dots();
            repeat (40) @(posedge clock);
         end
         row = random_line();
         gap = ((n / 40) % 4 == 3) ? 0 : $urandom_range(0, 6);
         drive_line(row, gap);
         trace_dots(row.sx, row.sy, row.ex, row.ey);
      end

      // Wait out the last dots, then a margin for stray words.
      drain_dots();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("dotted_dda_line_rasterizer_core_tb: clean");
      end else begin
         $display("dotted_dda_line_rasterizer_core_tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/dda_pkg.sv
design/dda_front.sv
design/dda_fifo.sv
design/dda_back.sv
design/dotted_dda_line_rasterizer_core.sv
design/dda_checker.sv
dv/dotted_dda_line_rasterizer_core_tb.sv
